FILE: rtl/clf_pkg.sv
// clf_pkg: shared constants, configuration codes and transaction types
// of the column line feature detector; no dependencies
package clf_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W  = 8;
  localparam int COL_W  = 12;
  localparam int ROW_W  = 12;
  localparam int DIM_W  = 13;
  localparam int GAP_W  = 12;
  localparam int CNT_W  = 4;
  localparam int WIN_N  = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = 2;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = 2;

  localparam int ENTRY_W = ROW_W + CNT_W;

  localparam logic [PIX_W-1:0] THR_RST    = 8'd5;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd4096;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd4096;
  localparam logic [GAP_W-1:0] GAP_RST    = 12'd2;
  localparam logic [CNT_W-1:0] MINSEG_RST = 4'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_WIDTH     = 3'd1,
    CFG_HEIGHT    = 3'd2,
    CFG_GAP       = 3'd3,
    CFG_MINSEG    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] threshold;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } front_cfg_t;

  typedef struct packed {
    logic [GAP_W-1:0] gap_limit;
    logic [CNT_W-1:0] min_segments;
  } back_cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             row_zero;
    logic             feat;
    logic             report;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             flagged;
    logic             last;
  } res_t;

endpackage

FILE: rtl/column_line_feature_detector.sv
// column_line_feature_detector: top level with configuration registers,
// front, transaction queue and back. depends on clf_pkg, clf_front,
// clf_cmd_queue, clf_back
//
//   channel  handshake          payload
//   in       in_push / in_full  in_pixel_value
//   out      out_pop / out_empty out_column_index, out_column_flagged, out_last_column
//   cfg      cfg_we             cfg_index, cfg_data
//
// one pixel per cycle sustained while in_full is low; a verdict reaches the out ports
// through the transaction queue, the column ram read, the update and the result queue
// reset is synchronous; column state needs no clearing, row 0 rewrites it
// a stalled result queue backs up into the 4-entry transaction queue, then in_full
module column_line_feature_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [clf_pkg::PIX_W-1:0]     in_pixel_value,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [clf_pkg::COL_W-1:0]     out_column_index,
  output logic                          out_column_flagged,
  output logic                          out_last_column,
  input  logic                          cfg_we,
  input  logic [clf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [clf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import clf_pkg::*;

  logic [PIX_W-1:0] thr_r;
  logic [DIM_W-1:0] width_r, height_r;
  logic [GAP_W-1:0] gap_r;
  logic [CNT_W-1:0] minseg_r;

  front_cfg_t fcfg;
  back_cfg_t  bcfg;
  cmd_t       cmd, cq_data;
  res_t       res;
  logic       cmd_push, cq_full, cq_pop, cq_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      gap_r    <= GAP_RST;
      minseg_r <= MINSEG_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_THRESHOLD: thr_r    <= cfg_data[PIX_W-1:0];
        CFG_WIDTH:     width_r  <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT:    height_r <= cfg_data[DIM_W-1:0];
        CFG_GAP:       gap_r    <= cfg_data[GAP_W-1:0];
        CFG_MINSEG:    minseg_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp frame size to 1 .. max
  always_comb begin
    fcfg.threshold = thr_r;
    if (width_r == '0) begin
      fcfg.width = DIM_W'(1);
    end else if (width_r > DIM_W'(MAX_WIDTH)) begin
      fcfg.width = DIM_W'(MAX_WIDTH);
    end else begin
      fcfg.width = width_r;
    end
    if (height_r == '0) begin
      fcfg.height = DIM_W'(1);
    end else if (height_r > DIM_W'(MAX_HEIGHT)) begin
      fcfg.height = DIM_W'(MAX_HEIGHT);
    end else begin
      fcfg.height = height_r;
    end
    bcfg.gap_limit    = gap_r;
    bcfg.min_segments = minseg_r;
  end

  clf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_pixel_value(in_pixel_value),
    .cfg           (fcfg),
    .cq_full       (cq_full),
    .cmd_push      (cmd_push),
    .cmd           (cmd)
  );

  clf_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_data(cmd),
    .full     (cq_full),
    .pop      (cq_pop),
    .pop_data (cq_data),
    .empty    (cq_empty)
  );

  clf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (bcfg),
    .cq_empty (cq_empty),
    .cq_data  (cq_data),
    .cq_pop   (cq_pop),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_res  (res)
  );

  assign in_full            = cq_full;
  assign out_column_index   = res.col;
  assign out_column_flagged = res.flagged;
  assign out_last_column    = res.last;

endmodule

FILE: rtl/clf_ram.sv
// clf_ram: generic single write port, single read port ram with registered read
// no dependencies
module clf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/clf_front.sv
// clf_front: pixel window, raster position and feature decision; emits one
// column update transaction per interior pixel. depends on clf_pkg
module clf_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  logic [clf_pkg::PIX_W-1:0]  in_pixel_value,
  input  clf_pkg::front_cfg_t        cfg,
  input  logic                       cq_full,
  output logic                       cmd_push,
  output clf_pkg::cmd_t              cmd
);
  import clf_pkg::*;

  logic [PIX_W-1:0] win_r [WIN_N];
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             accept;
  logic             in_frame;
  logic             feat;
  logic [DIM_W-1:0] col_ext, row_ext;

  assign accept   = in_push && !cq_full;
  assign col_ext  = {1'b0, col_r};
  assign row_ext  = {1'b0, row_r};
  assign in_frame = (col_ext < cfg.width) && (col_r >= COL_W'(4));

  assign feat = (win_r[1] > cfg.threshold) && (win_r[3] >= cfg.threshold) &&
                (win_r[2] >= cfg.threshold) && (win_r[0] >= cfg.threshold) &&
                (in_pixel_value >= cfg.threshold);

  always_comb begin
    cmd.col      = col_r - COL_W'(2);
    cmd.row      = row_r;
    cmd.row_zero = (row_r == '0);
    cmd.feat     = feat;
    cmd.report   = (row_ext == cfg.height - DIM_W'(1));
    cmd.last     = (col_ext == cfg.width - DIM_W'(1));
    cmd_push     = accept && in_frame;
  end

  always_comb begin
    col_nxt = col_r + COL_W'(1);
    row_nxt = row_r;
    if (col_ext + DIM_W'(1) >= cfg.width) begin
      col_nxt = '0;
      row_nxt = (row_ext + DIM_W'(1) >= cfg.height) ? '0 : row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      for (int i = 0; i < WIN_N; i++) begin
        win_r[i] <= '0;
      end
    end else if (accept) begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      win_r[0] <= in_pixel_value;
      for (int i = 1; i < WIN_N; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

endmodule

FILE: rtl/clf_cmd_queue.sv
// clf_cmd_queue: short flop queue of column update transactions between
// front and back. depends on clf_pkg
module clf_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  clf_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output clf_pkg::cmd_t pop_data,
  output logic          empty
);
  import clf_pkg::*;

  cmd_t             mem_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wptr_r, rptr_r;
  logic [CQ_AW:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == (CQ_AW+1)'(CQ_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (CQ_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (CQ_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wptr_r <= wptr_r + CQ_AW'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + CQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/clf_back.sv
// clf_back: read-modify-write of the per-column segment state and the result
// queue. depends on clf_pkg and clf_ram
module clf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  clf_pkg::back_cfg_t cfg,
  input  logic          cq_empty,
  input  clf_pkg::cmd_t cq_data,
  output logic          cq_pop,
  input  logic          out_pop,
  output logic          out_empty,
  output clf_pkg::res_t out_res
);
  import clf_pkg::*;

  localparam int CRED_W = OQ_AW + 2;

  logic               issue;
  logic               sb_valid_r;
  cmd_t               sb_cmd_r;
  logic               fwd_hit_r;
  logic [ENTRY_W-1:0] fwd_data_r;
  logic [ENTRY_W-1:0] ram_rdata, old_entry, wr_entry;
  logic [CNT_W-1:0]   old_cnt, new_cnt;
  logic [ROW_W-1:0]   old_last, new_last, gap;

  res_t               oq_mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0]   oq_wptr_r, oq_rptr_r;
  logic [OQ_AW:0]     oq_count_r, oq_count_nxt;
  logic               oq_push, oq_pop;
  res_t               res;

  assign issue  = !cq_empty &&
                  (CRED_W'(oq_count_r) + CRED_W'(sb_valid_r) < CRED_W'(OQ_DEPTH));
  assign cq_pop = issue;

  clf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_WIDTH)
  ) u_col_ram (
    .clk  (clk),
    .we   (sb_valid_r),
    .waddr(sb_cmd_r.col),
    .wdata(wr_entry),
    .re   (issue),
    .raddr(cq_data.col),
    .rdata(ram_rdata)
  );

  // bypass when a column is read in the cycle it is written
  assign old_entry = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign old_cnt   = old_entry[CNT_W-1:0];
  assign old_last  = old_entry[ENTRY_W-1:CNT_W];
  assign gap       = sb_cmd_r.row - old_last;

  always_comb begin
    new_cnt  = old_cnt;
    new_last = old_last;
    if (sb_cmd_r.row_zero) begin
      new_cnt  = sb_cmd_r.feat ? CNT_W'(1) : '0;
      new_last = '0;
    end else if (sb_cmd_r.feat) begin
      if (old_cnt == '0) begin
        new_cnt = CNT_W'(1);
      end else if (gap > cfg.gap_limit && old_cnt != CNT_MAX) begin
        new_cnt = old_cnt + CNT_W'(1);
      end
      new_last = sb_cmd_r.row;
    end
    wr_entry = {new_last, new_cnt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      sb_valid_r <= issue;
      fwd_hit_r  <= issue && sb_valid_r && (cq_data.col == sb_cmd_r.col);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      sb_cmd_r <= cq_data;
    end
    fwd_data_r <= wr_entry;
  end

  // result queue
  assign res.col     = sb_cmd_r.col;
  assign res.flagged = (new_cnt >= cfg.min_segments);
  assign res.last    = sb_cmd_r.last;
  assign oq_push     = sb_valid_r && sb_cmd_r.report;
  assign oq_pop      = out_pop && !out_empty;
  assign out_empty   = (oq_count_r == '0);
  assign out_res     = oq_mem_r[oq_rptr_r];

  always_comb begin
    oq_count_nxt = oq_count_r;
    if (oq_push && !oq_pop) begin
      oq_count_nxt = oq_count_r + (OQ_AW+1)'(1);
    end else if (oq_pop && !oq_push) begin
      oq_count_nxt = oq_count_r - (OQ_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wptr_r  <= '0;
      oq_rptr_r  <= '0;
      oq_count_r <= '0;
    end else begin
      oq_count_r <= oq_count_nxt;
      if (oq_push) begin
        oq_wptr_r <= oq_wptr_r + OQ_AW'(1);
      end
      if (oq_pop) begin
        oq_rptr_r <= oq_rptr_r + OQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_mem_r[oq_wptr_r] <= res;
    end
  end

  a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> (oq_count_r < (OQ_AW+1)'(OQ_DEPTH)))
    else $error("result queue written while full");

  a_oq_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    oq_count_r <= (OQ_AW+1)'(OQ_DEPTH))
    else $error("result queue count out of range");

  a_issue_to_update: assert property (@(posedge clk) disable iff (!rst_n)
    issue |=> sb_valid_r)
    else $error("issued transaction lost before update");

  a_fwd_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> sb_valid_r)
    else $error("bypass without update in flight");

endmodule
